/* design/nsi_pkg.sv */
// ----------------------------------------------------------------------------
// nsi_pkg: shared types and lexer helpers for the semicolon inserter
// character classes, keyword table, lexer modes and the front-to-back command
// ----------------------------------------------------------------------------
package nsi_pkg;

    localparam int HOLD_DEPTH_DEF = 32;
    localparam int WORD_LIMIT_DEF = 127;
    localparam int QUEUE_DEPTH    = 4;
    localparam int KW_COUNT       = 29;
    localparam int KW_TRIGGERING  = 5;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;

    // keywords, left-justified and padded to nine characters
    localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
        "return   ", "suspend  ", "fail     ", "break    ", "next     ",
        "end      ", "then     ", "else     ", "do       ", "to       ",
        "by       ", "not      ", "of       ", "initial  ", "if       ",
        "while    ", "until    ", "repeat   ", "every    ", "local    ",
        "static   ", "global   ", "procedure", "record   ", "link     ",
        "invocable", "create   ", "case     ", "default  "
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd6, 4'd7, 4'd4, 4'd5, 4'd4, 4'd3, 4'd4, 4'd4, 4'd2, 4'd2, 4'd2, 4'd3,
        4'd2, 4'd7, 4'd2, 4'd5, 4'd5, 4'd6, 4'd5, 4'd5, 4'd6, 4'd6, 4'd9, 4'd6,
        4'd4, 4'd9, 4'd6, 4'd4, 4'd7
    };

    typedef enum logic [9:0] {
        M_GAP        = 10'b0000000001,
        M_IDENT      = 10'b0000000010,
        M_INT        = 10'b0000000100,
        M_DOT        = 10'b0000001000,
        M_FRAC       = 10'b0000010000,
        M_EXP_START  = 10'b0000100000,
        M_EXP_DIGITS = 10'b0001000000,
        M_RADIX      = 10'b0010000000,
        M_QUOTED     = 10'b0100000000,
        M_COMMENT    = 10'b1000000000
    } t_mode;

    // output slots of one transaction, in emission order
    typedef enum logic [4:0] {
        P_PRE_SEMI  = 5'b00001,
        P_PRE_BLK   = 5'b00010,
        P_BYTE      = 5'b00100,
        P_POST_SEMI = 5'b01000,
        P_POST_BLK  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic       pre_semi;
        logic       pre_rel;
        logic       emit;
        logic       hold;
        logic       post_semi;
        logic       post_rel;
        logic       ovf;
        logic [7:0] ch;
    } t_cmd;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    endfunction

    function automatic logic [7:0] kw_char(input int i, input logic [6:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (pos < 7'd9) begin
            ch = KW_TEXT[i][8*(8-int'(pos[3:0])) +: 8];
        end
        kw_char = ch;
    endfunction

    // drop every keyword that cannot match with c at position wl
    function automatic logic [KW_COUNT-1:0] kw_filter(input logic [KW_COUNT-1:0] kc,
                                                      input logic [6:0] wl,
                                                      input logic [7:0] c);
        logic [KW_COUNT-1:0] r;
        r = kc;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (!((wl < 7'(KW_LEN[i])) && (kw_char(i, wl) == c))) begin
                r[i] = 1'b0;
            end
        end
        kw_filter = r;
    endfunction

    function automatic logic word_triggers(input logic [KW_COUNT-1:0] kc,
                                           input logic [6:0] wl);
        logic t;
        t = 1'b1;
        for (int i = KW_TRIGGERING; i < KW_COUNT; i++) begin
            if (kc[i] && (7'(KW_LEN[i]) == wl)) begin
                t = 1'b0;
            end
        end
        word_triggers = t;
    endfunction

endpackage

/* design/nsi_front.sv */
// ----------------------------------------------------------------------------
// nsi_front: lexer front end
// classifies each accepted byte and pushes at most one command to the queue
// ----------------------------------------------------------------------------
module nsi_front
    import nsi_pkg::*;
#(
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF,
    parameter int WORD_LIMIT = WORD_LIMIT_DEF,
    localparam int CW = $clog2(HOLD_DEPTH + 1)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_eoi,
    input  logic       i_q_full,
    output logic       o_stall,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_mode               r_mode, n_mode;
    logic                r_ltt, n_ltt;
    logic [KW_COUNT-1:0] r_kc, n_kc;
    logic [6:0]          r_wl, n_wl;
    logic                r_qk, n_qk;
    logic                r_esc, n_esc;
    logic [CW-1:0]       r_hc, n_hc;
    logic                r_ovf, n_ovf;

    logic accept;
    t_cmd cmd;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        logic       do_end;
        logic       do_gap;
        logic [7:0] c;
        logic [7:0] delim;
        n_mode = r_mode;
        n_ltt  = r_ltt;
        n_kc   = r_kc;
        n_wl   = r_wl;
        n_qk   = r_qk;
        n_esc  = r_esc;
        n_hc   = r_hc;
        n_ovf  = r_ovf;
        cmd    = '0;
        c      = i_byte;
        cmd.ch = c;
        do_end = 1'b0;
        do_gap = 1'b0;
        delim  = r_qk ? CH_SQUOTE : CH_DQUOTE;

        case (r_mode)
            M_COMMENT: begin
                cmd.emit = 1'b1;
                if (c == CH_NL) begin
                    n_mode = M_GAP;
                    n_ltt  = 1'b0;
                end
            end
            M_QUOTED: begin
                if (c == CH_NL) begin
                    do_end = 1'b1;
                end else begin
                    cmd.emit = 1'b1;
                    if (r_esc) begin
                        n_esc = 1'b0;
                    end else if (c == CH_BSLASH) begin
                        n_esc = 1'b1;
                    end else if (c == delim) begin
                        n_ltt  = 1'b1;
                        n_mode = M_GAP;
                    end
                end
            end
            M_IDENT: begin
                if ((is_digit(c) || is_alpha(c) || c == CH_UNDER)
                    && (r_wl < 7'(WORD_LIMIT))) begin
                    cmd.emit = 1'b1;
                    n_kc     = kw_filter(r_kc, r_wl, c);
                    n_wl     = (r_wl < 7'd127) ? r_wl + 7'd1 : r_wl;
                end else begin
                    do_end = 1'b1;
                end
            end
            M_INT: begin
                cmd.emit = 1'b1;
                if (is_digit(c)) begin
                    n_mode = M_INT;
                end else if (c == 8'h72 || c == 8'h52) begin
                    n_mode = M_RADIX;
                end else if (c == CH_DOT) begin
                    n_mode = M_DOT;
                end else if (c == 8'h65 || c == 8'h45) begin
                    n_mode = M_EXP_START;
                end else begin
                    cmd.emit = 1'b0;
                    do_end   = 1'b1;
                end
            end
            M_DOT: begin
                if (is_digit(c)) begin
                    cmd.emit = 1'b1;
                    n_mode   = M_FRAC;
                end else begin
                    do_end = 1'b1;
                end
            end
            M_FRAC: begin
                cmd.emit = 1'b1;
                if (c == 8'h65 || c == 8'h45) begin
                    n_mode = M_EXP_START;
                end else if (!is_digit(c)) begin
                    cmd.emit = 1'b0;
                    do_end   = 1'b1;
                end
            end
            M_EXP_START: begin
                if (c == CH_PLUS || c == CH_MINUS || is_digit(c)) begin
                    cmd.emit = 1'b1;
                    n_mode   = M_EXP_DIGITS;
                end else begin
                    do_end = 1'b1;
                end
            end
            M_EXP_DIGITS: begin
                if (is_digit(c)) begin
                    cmd.emit = 1'b1;
                end else begin
                    do_end = 1'b1;
                end
            end
            M_RADIX: begin
                if (is_digit(c) || is_alpha(c)) begin
                    cmd.emit = 1'b1;
                end else begin
                    do_end = 1'b1;
                end
            end
            default: begin
                do_gap = 1'b1;
            end
        endcase

        if (do_end) begin
            if (r_mode == M_IDENT) begin
                n_ltt = word_triggers(r_kc, r_wl);
            end else if (r_mode == M_DOT) begin
                n_ltt = 1'b0;
            end else begin
                n_ltt = 1'b1;
            end
            n_mode = M_GAP;
            n_esc  = 1'b0;
            do_gap = 1'b1;
        end

        if (do_gap) begin
            n_mode = M_GAP;
            if (c == CH_NL) begin
                cmd.pre_semi = n_ltt;
                cmd.pre_rel  = 1'b1;
                cmd.emit     = 1'b1;
                n_hc         = '0;
                n_ltt        = 1'b0;
            end else if (is_blank(c)) begin
                if (n_ltt) begin
                    if (r_hc < CW'(HOLD_DEPTH)) begin
                        cmd.hold = 1'b1;
                        n_hc     = r_hc + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end else begin
                    cmd.emit = 1'b1;
                end
            end else if (c == CH_HASH) begin
                cmd.pre_semi = n_ltt;
                cmd.pre_rel  = 1'b1;
                cmd.emit     = 1'b1;
                n_hc         = '0;
                n_ltt        = 1'b0;
                n_mode       = M_COMMENT;
            end else begin
                cmd.pre_rel = 1'b1;
                cmd.emit    = 1'b1;
                n_hc        = '0;
                n_ltt       = 1'b0;
                if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                    n_qk   = (c == CH_SQUOTE);
                    n_esc  = 1'b0;
                    n_mode = M_QUOTED;
                end else if (is_digit(c)) begin
                    n_mode = M_INT;
                end else if (is_alpha(c) || c == CH_UNDER) begin
                    n_kc   = kw_filter('1, 7'd0, c);
                    n_wl   = 7'd1;
                    n_mode = M_IDENT;
                end else begin
                    n_ltt = (c == CH_RPAREN) || (c == CH_RBRACK);
                end
            end
        end

        // end of text closes the open line without a newline
        if (i_eoi) begin
            if (n_mode != M_COMMENT) begin
                if (n_mode == M_IDENT) begin
                    n_ltt = word_triggers(n_kc, n_wl);
                end else if (n_mode == M_DOT) begin
                    n_ltt = 1'b0;
                end else if (n_mode != M_GAP) begin
                    n_ltt = 1'b1;
                end
                cmd.post_semi = n_ltt;
                cmd.post_rel  = 1'b1;
            end
            n_mode = M_GAP;
            n_ltt  = 1'b0;
            n_kc   = '1;
            n_wl   = 7'd0;
            n_qk   = 1'b0;
            n_esc  = 1'b0;
            n_hc   = '0;
        end
        cmd.ovf = n_ovf;
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.pre_semi || cmd.emit || cmd.hold || cmd.post_semi
                    || ((cmd.pre_rel || cmd.post_rel) && (r_hc != '0)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_GAP;
            r_ltt  <= 1'b0;
            r_kc   <= '1;
            r_wl   <= 7'd0;
            r_qk   <= 1'b0;
            r_esc  <= 1'b0;
            r_hc   <= '0;
            r_ovf  <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_ltt  <= n_ltt;
            r_kc   <= n_kc;
            r_wl   <= n_wl;
            r_qk   <= n_qk;
            r_esc  <= n_esc;
            r_hc   <= n_hc;
            r_ovf  <= n_ovf;
        end
    end

endmodule

/* design/nsi_queue.sv */
// ----------------------------------------------------------------------------
// nsi_queue: command queue
// small fifo that decouples the lexer from the byte emitter
// ----------------------------------------------------------------------------
module nsi_queue
    import nsi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

endmodule

/* design/nsi_back.sv */
// ----------------------------------------------------------------------------
// nsi_back: byte emitter
// walks each command slot by slot, keeps the held blanks, drives the output
// ----------------------------------------------------------------------------
module nsi_back
    import nsi_pkg::*;
#(
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF,
    localparam int CW = $clog2(HOLD_DEPTH + 1),
    localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  logic       i_empty,
    output logic       o_pop,
    output logic [CW-1:0] o_held,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_byte,
    output logic       o_last,
    output logic       o_ovf
);

    logic [7:0]    r_buf [HOLD_DEPTH];
    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_cnt;
    logic          r_ov;
    logic [7:0]    r_byte;
    logic          r_last, r_ovf;

    logic [4:0]    ge, avail, sel;
    logic [CW-1:0] n4, base_mid;
    logic [CW:0]   idx_inc;
    logic          found, more, stay, go, load;
    logic [7:0]    data;

    assign base_mid = i_head.pre_rel ? '0 : r_cnt;
    assign n4       = base_mid + CW'(i_head.hold);
    assign idx_inc  = {1'b0, r_idx} + (CW+1)'(1);

    // slots at or after the current phase
    assign ge[0] = r_phase[0];
    assign ge[1] = |r_phase[1:0];
    assign ge[2] = |r_phase[2:0];
    assign ge[3] = |r_phase[3:0];
    assign ge[4] = 1'b1;

    always_comb begin
        logic [CW-1:0] i1, i4;
        i1 = r_phase[1] ? r_idx : '0;
        i4 = r_phase[4] ? r_idx : '0;
        avail[0] = i_head.pre_semi;
        avail[1] = i_head.pre_rel && (i1 < r_cnt);
        avail[2] = i_head.emit;
        avail[3] = i_head.post_semi;
        avail[4] = i_head.post_rel && (i4 < n4);
        avail    = avail & ge & {5{!i_empty}};
    end

    assign sel   = avail & (~avail + 5'd1);
    assign found = |sel;
    assign stay  = (sel[1] && (idx_inc < {1'b0, r_cnt}))
                || (sel[4] && (idx_inc < {1'b0, n4}));
    assign more  = stay || (|(avail & ~(sel | (sel - 5'd1))));
    assign go    = !r_ov || !i_stall;
    assign load  = go && found;
    assign o_pop = !i_empty && (!found || (load && !more));

    always_comb begin
        data = CH_SEMI;
        if (sel[2]) begin
            data = i_head.ch;
        end else if (sel[1] || sel[4]) begin
            // a blank held by this same transaction is read from the command
            if (sel[4] && i_head.hold && (r_idx == r_cnt)) begin
                data = i_head.ch;
            end else begin
                data = r_buf[r_idx[AW-1:0]];
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        if (o_pop) begin
            n_phase = P_PRE_SEMI;
            n_idx   = '0;
        end else if (load) begin
            if (stay) begin
                n_idx = idx_inc[CW-1:0];
            end else begin
                n_phase = t_phase'(sel << 1);
                n_idx   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.hold) begin
            r_buf[r_cnt[AW-1:0]] <= i_head.ch;
        end
        if (load) begin
            r_byte <= data;
            r_last <= !more;
            r_ovf  <= i_head.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_PRE_SEMI;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            if (go) begin
                r_ov <= found;
            end
            if (o_pop) begin
                r_cnt <= i_head.post_rel ? '0 : n4;
            end
        end
    end

    assign o_held  = r_cnt;
    assign o_valid = r_ov;
    assign o_byte  = r_byte;
    assign o_last  = r_last;
    assign o_ovf   = r_ovf;

endmodule

/* design/newline_semicolon_inserter.sv */
// ----------------------------------------------------------------------------
// newline_semicolon_inserter: echoes source bytes, adds ';' at line ends
// lexer front end, command queue and byte emitter
// ----------------------------------------------------------------------------
// One byte is taken per cycle until the four-entry command queue fills,
// which happens while the emitter works through a line-end burst of up to
// HOLD_DEPTH + 2 bytes (';', held blanks, the byte itself) or while the
// output side is stalled; each output byte is held in a register, and the
// emitter loads the next one as soon as the current one is taken. Blanks
// after a triggering token are held, not echoed, until the next byte decides
// where the ';' goes; blanks beyond HOLD_DEPTH are dropped and o_overflow
// stays high from then on. o_last_of_run marks the final byte caused by one
// input transaction; a transaction may cause no output at all.
module newline_semicolon_inserter
    import nsi_pkg::*;
#(
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF,
    parameter int WORD_LIMIT = WORD_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_overflow
);

    localparam int CW = $clog2(HOLD_DEPTH + 1);

    logic          q_push, q_pop, q_full, q_empty;
    t_cmd          q_in, q_head;
    logic [CW-1:0] held;

    nsi_front #(
        .HOLD_DEPTH (HOLD_DEPTH),
        .WORD_LIMIT (WORD_LIMIT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_byte   (i_in_byte),
        .i_eoi    (i_end_of_input),
        .i_q_full (q_full),
        .o_stall  (o_in_stall),
        .o_push   (q_push),
        .o_cmd    (q_in)
    );

    nsi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    nsi_back #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_held  (held),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_byte  (o_out_byte),
        .o_last  (o_last_of_run),
        .o_ovf   (o_overflow)
    );

`ifndef SYNTH
    // the lexer never pushes into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full)) else $error("command pushed into full queue");

    // the emitter never pops an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_empty)) else $error("command popped from empty queue");

    // held blank count stays within the buffer
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        held <= CW'(HOLD_DEPTH)) else $error("held blank count out of range");

    // once reported, overflow stays reported on later output bytes
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_overflow) |=> (!o_out_valid || o_overflow))
        else $error("overflow flag cleared");
`endif

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for newline_semicolon_inserter
// feeds source text lines byte by byte, predicts the echoed stream with the
// inserted semicolons and held blanks, and checks every output transaction
// ----------------------------------------------------------------------------
module tb;
    import nsi_pkg::*;

    localparam int HOLD = HOLD_DEPTH_DEF;
    localparam int WLIM = WORD_LIMIT_DEF;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
    } t_src;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       ovf;
    } t_emit;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_end_of_input = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;
    logic       o_overflow;

    newline_semicolon_inserter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_in_byte(i_in_byte), .i_end_of_input(i_end_of_input),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_byte(o_out_byte), .o_last_of_run(o_last_of_run),
        .o_overflow(o_overflow)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    t_mode               lx_mode = M_GAP;
    logic                lx_trig = 1'b0;
    logic [KW_COUNT-1:0] lx_kc = '1;
    int                  lx_wlen = 0;
    logic                lx_squote = 1'b0;
    logic                lx_esc = 1'b0;
    logic [7:0]          lx_held [HOLD];
    int                  lx_nheld = 0;
    logic                lx_ovf = 1'b0;
    logic [7:0]          step_bytes [$];

    t_src  src_queue [$];
    t_emit expected_bytes [$];

    int  errors = 0;
    int  quiet_cycles = 0;
    bit  sender_pause = 1'b0;
    bit  no_idle = 1'b0;
    int  hold_off = 0;
    bit  stim_done = 1'b0;
    bit  in_taken = 1'b0;

    function automatic bit is_alnum_c(logic [7:0] c);
        return is_digit(c) || is_alpha(c);
    endfunction

    function automatic logic [7:0] keyword_char(int k, int pos);
        if (pos >= 9) return 8'h00;
        return KW_TEXT[k][8*(8-pos) +: 8];
    endfunction

    function automatic void add_letter(logic [7:0] c);
        for (int k = 0; k < KW_COUNT; k++)
            if (!(lx_wlen < int'(KW_LEN[k]) && keyword_char(k, lx_wlen) == c))
                lx_kc[k] = 1'b0;
        if (lx_wlen < 127) lx_wlen++;
    endfunction

    function automatic logic ident_triggers();
        for (int k = KW_TRIGGERING; k < KW_COUNT; k++)
            if (lx_kc[k] && int'(KW_LEN[k]) == lx_wlen) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void close_token();
        if (lx_mode == M_IDENT) lx_trig = ident_triggers();
        else if (lx_mode == M_DOT || lx_mode == M_GAP || lx_mode == M_COMMENT)
            lx_trig = 1'b0;
        else lx_trig = 1'b1;
        lx_mode = M_GAP;
        lx_esc = 1'b0;
    endfunction

    function automatic void flush_held(bit semi);
        if (semi && lx_trig) step_bytes.push_back(CH_SEMI);
        for (int k = 0; k < lx_nheld; k++) step_bytes.push_back(lx_held[k]);
        lx_nheld = 0;
    endfunction

    function automatic void between_tokens(logic [7:0] c);
        lx_mode = M_GAP;
        if (c == CH_NL) begin
            flush_held(1);
            step_bytes.push_back(c);
            lx_trig = 1'b0;
        end else if (is_blank(c)) begin
            if (lx_trig) begin
                if (lx_nheld < HOLD) lx_held[lx_nheld++] = c;
                else lx_ovf = 1'b1;
            end else begin
                step_bytes.push_back(c);
            end
        end else if (c == CH_HASH) begin
            flush_held(1);
            step_bytes.push_back(c);
            lx_trig = 1'b0;
            lx_mode = M_COMMENT;
        end else begin
            flush_held(0);
            step_bytes.push_back(c);
            lx_trig = 1'b0;
            if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                lx_squote = (c == CH_SQUOTE);
                lx_esc = 1'b0;
                lx_mode = M_QUOTED;
            end else if (is_digit(c)) begin
                lx_mode = M_INT;
            end else if (is_alpha(c) || c == CH_UNDER) begin
                lx_kc = '1;
                lx_wlen = 0;
                add_letter(c);
                lx_mode = M_IDENT;
            end else begin
                lx_trig = (c == CH_RPAREN || c == CH_RBRACK);
            end
        end
    endfunction

    function automatic void close_and_gap(logic [7:0] c);
        close_token();
        between_tokens(c);
    endfunction

    function automatic void predict_byte(logic [7:0] c, logic eoi);
        step_bytes.delete();
        case (lx_mode)
            M_COMMENT: begin
                step_bytes.push_back(c);
                if (c == CH_NL) begin
                    lx_mode = M_GAP;
                    lx_trig = 1'b0;
                end
            end
            M_QUOTED: begin
                if (c == CH_NL) close_and_gap(c);
                else begin
                    step_bytes.push_back(c);
                    if (lx_esc) lx_esc = 1'b0;
                    else if (c == CH_BSLASH) lx_esc = 1'b1;
                    else if (c == (lx_squote ? CH_SQUOTE : CH_DQUOTE)) begin
                        lx_trig = 1'b1;
                        lx_mode = M_GAP;
                    end
                end
            end
            M_IDENT: begin
                if ((is_alnum_c(c) || c == CH_UNDER) && lx_wlen < WLIM) begin
                    step_bytes.push_back(c);
                    add_letter(c);
                end else close_and_gap(c);
            end
            M_INT: begin
                if (is_digit(c)) step_bytes.push_back(c);
                else if (c == "r" || c == "R") begin
                    step_bytes.push_back(c); lx_mode = M_RADIX;
                end else if (c == CH_DOT) begin
                    step_bytes.push_back(c); lx_mode = M_DOT;
                end else if (c == "e" || c == "E") begin
                    step_bytes.push_back(c); lx_mode = M_EXP_START;
                end else close_and_gap(c);
            end
            M_DOT: begin
                if (is_digit(c)) begin
                    step_bytes.push_back(c); lx_mode = M_FRAC;
                end else close_and_gap(c);
            end
            M_FRAC: begin
                if (is_digit(c)) step_bytes.push_back(c);
                else if (c == "e" || c == "E") begin
                    step_bytes.push_back(c); lx_mode = M_EXP_START;
                end else close_and_gap(c);
            end
            M_EXP_START: begin
                if (c == CH_PLUS || c == CH_MINUS || is_digit(c)) begin
                    step_bytes.push_back(c); lx_mode = M_EXP_DIGITS;
                end else close_and_gap(c);
            end
            M_EXP_DIGITS: begin
                if (is_digit(c)) step_bytes.push_back(c);
                else close_and_gap(c);
            end
            M_RADIX: begin
                if (is_alnum_c(c)) step_bytes.push_back(c);
                else close_and_gap(c);
            end
            default: between_tokens(c);
        endcase
        if (eoi) begin
            if (lx_mode != M_COMMENT) begin
                if (lx_mode != M_GAP) close_token();
                flush_held(1);
            end
            lx_mode = M_GAP;
            lx_trig = 1'b0;
            lx_kc = '1;
            lx_wlen = 0;
            lx_squote = 1'b0;
            lx_esc = 1'b0;
            lx_nheld = 0;
        end
        foreach (step_bytes[k]) begin
            t_emit e;
            e.ch = step_bytes[k];
            e.last = (k == step_bytes.size() - 1);
            e.ovf = lx_ovf;
            expected_bytes.push_back(e);
        end
    endfunction

    // driver: change at falling edge, a new byte only once the last one was taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                in_taken = 1'b0;
                if (src_queue.size() > 0 && !sender_pause &&
                    (no_idle || $urandom_range(99) >= 15)) begin
                    t_src s;
                    s = src_queue.pop_front();
                    i_in_byte <= s.ch;
                    i_end_of_input <= s.eoi;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls and a counted hold-off stretch
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_off > 0) begin
                i_out_stall <= 1'b1;
                hold_off <= hold_off - 1;
            end else begin
                i_out_stall <= !no_idle && ($urandom_range(99) < 15);
            end
        end
    end

    // monitor: predict on input acceptance, check on output acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            bit moved;
            moved = 1'b0;
            if (i_in_valid && !o_in_stall) begin
                predict_byte(i_in_byte, i_end_of_input);
                in_taken = 1'b1;
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (expected_bytes.size() == 0) begin
                    $error("unexpected output byte %h", o_out_byte);
                    errors++;
                end else begin
                    t_emit e;
                    e = expected_bytes.pop_front();
                    if (o_out_byte !== e.ch) begin
                        $error("out_byte expected %h actual %h", e.ch, o_out_byte);
                        errors++;
                    end
                    if (o_last_of_run !== e.last) begin
                        $error("last_of_run expected %b actual %b", e.last, o_last_of_run);
                        errors++;
                    end
                    if (o_overflow !== e.ovf) begin
                        $error("overflow expected %b actual %b", e.ovf, o_overflow);
                        errors++;
                    end
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles > 4000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void push_text(string s, bit eoi_at_end);
        for (int k = 0; k < s.len(); k++) begin
            t_src x;
            x.ch = s[k];
            x.eoi = eoi_at_end && (k == s.len() - 1);
            src_queue.push_back(x);
        end
    endfunction

    function automatic string rand_ident();
        string words [12] = '{"return", "suspend", "fail", "break", "next", "end",
                              "then", "procedure", "x", "count_1", "invocable", "Q"};
        return words[$urandom_range(11)];
    endfunction

    function automatic string rand_token();
        string s;
        case ($urandom_range(11))
            0, 1, 2: s = rand_ident();
            3: s = $sformatf("%0d", $urandom_range(9999));
            4: s = $sformatf("%0d.%0de-%0d", $urandom_range(99), $urandom_range(9),
                             $urandom_range(9));
            5: s = "16rFF";
            6: s = "\"a\\\"b\"";
            7: s = "'xyz'";
            8: s = ")";
            9: s = "]";
            10: s = "}";
            default: s = ":=";
        endcase
        return s;
    endfunction

    function automatic string rand_line();
        string s;
        int n;
        n = $urandom_range(4);
        s = "";
        for (int k = 0; k < n; k++) begin
            s = {s, rand_token()};
            if ($urandom_range(2) != 0) s = {s, " "};
        end
        case ($urandom_range(5))
            0: s = {s, "\t\r "};
            1: s = {s, "  # note x"};
            2: s = {s, "\"open"};
            default: ;
        endcase
        return {s, "\n"};
    endfunction

    task automatic drain();
        while (src_queue.size() > 0 || i_in_valid || expected_bytes.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        string w;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines
        push_text("x := 1\n", 0);
        push_text("return   # done\n", 0);
        push_text("end\n", 0);
        push_text("f(a]  \n", 0);
        push_text("3. \n", 0);
        push_text("\"unterminated \\\n", 0);
        push_text("{}\n", 0);
        push_text("next", 1);
        w = "";
        repeat (WLIM + 3) w = {w, "a"};
        push_text({w, "\n"}, 0);
        // a spread of byte values through a comment and as punctuation
        push_text("#", 0);
        for (int k = 0; k < 256; k += 7) begin
            t_src x;
            x.ch = (k == 10) ? 8'hFF : k[7:0];
            x.eoi = 1'b0;
            src_queue.push_back(x);
        end
        push_text("\n", 0);
        for (int k = 128; k < 256; k += 37) begin
            t_src x;
            x.ch = k[7:0];
            x.eoi = 1'b0;
            src_queue.push_back(x);
        end
        // overflow the blank hold
        w = "y";
        repeat (HOLD + 4) w = {w, " "};
        push_text({w, "z\n"}, 0);
        drain();

        // a line with a long run of held blanks, then the receiver holds off
        sender_pause = 1'b1;
        push_text({"abc", "                        ", "\n"}, 0);
        sender_pause = 1'b0;
        @(negedge i_clk);
        hold_off = 60;
        drain();

        for (int k = 0; k < 7; k++) begin
            no_idle = (k >= 1 && k < 5);
            push_text(rand_line(), $urandom_range(9) == 0);
            if ($urandom_range(7) == 0) begin
                t_src x;
                x.ch = 8'($urandom_range(255));
                x.eoi = 1'($urandom_range(1));
                src_queue.push_back(x);
            end
            while (src_queue.size() > 8) @(posedge i_clk);
        end
        no_idle = 1'b0;
        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && expected_bytes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

/* newline_semicolon_inserter.f */
design/nsi_pkg.sv
design/nsi_front.sv
design/nsi_queue.sv
design/nsi_back.sv
design/newline_semicolon_inserter.sv
bench/tb.sv
